/* hdl/rarst_pkg.sv */
`timescale 1ns / 1ps

package rarst_pkg;

  // tree geometry
  localparam int LEAF_COUNT  = 1024;
  localparam int LEVELS      = 11;
  localparam int NODE_COUNT  = 2 * LEAF_COUNT;
  localparam int POS_W       = 10;
  localparam int NODE_W      = 11;
  localparam int LVL_W       = 4;
  localparam int OP_W        = 2;
  localparam int VAL_W       = 32;
  localparam int SUM_W       = 64;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } rarst_op_e;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_ZERO  = 2'd3
  } rarst_kind_e;

  typedef struct packed {
    rarst_kind_e             kind;
    logic [NODE_W-1:0]       lo;     // leaf node for a write, left boundary otherwise
    logic [NODE_W-1:0]       hi;     // right boundary node
    logic [SUM_W-1:0]        value;  // sign extended operand
  } rarst_cmd_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } rarst_bstat_t;

endpackage

/* hdl/rarst_front.sv */
`timescale 1ns / 1ps

module rarst_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 operation_i,
  input  logic [9:0]                 left_index_i,
  input  logic [9:0]                 right_index_i,
  input  logic signed [31:0]         value_i,
  input  rarst_pkg::rarst_bstat_t    bstat_i,
  output logic                       cmd_valid_o,
  output rarst_pkg::rarst_cmd_t      cmd_o
);
  import rarst_pkg::*;

  rarst_cmd_t          queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;
  rarst_cmd_t          new_cmd;
  logic                keep;
  logic                good;
  logic                accept;
  logic                push;

  // range check: boundaries left-1 and right+1 must be inside the tree
  assign good = (left_index_i != '0) && (left_index_i <= right_index_i) &&
                (right_index_i <= POS_W'(LEAF_COUNT - 2));

  // classify the request
  always_comb begin
    new_cmd.kind  = CMD_ZERO;
    new_cmd.lo    = NODE_W'({1'b1, left_index_i}) - NODE_W'(1);
    new_cmd.hi    = NODE_W'({1'b1, right_index_i}) + NODE_W'(1);
    new_cmd.value = {{(SUM_W-VAL_W){value_i[VAL_W-1]}}, value_i};
    keep          = 1'b0;
    unique case (rarst_op_e'(operation_i))
      OP_WRITE: begin
        new_cmd.kind = CMD_WRITE;
        new_cmd.lo   = {1'b1, left_index_i};
        keep         = 1'b1;
      end
      OP_ADD: begin
        new_cmd.kind = CMD_ADD;
        keep         = good;
      end
      OP_QUERY: begin
        new_cmd.kind = good ? CMD_QUERY : CMD_ZERO;
        keep         = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall_o  = (count_q == QCNT_W'(QUEUE_DEPTH)) || bstat_i.clearing;
  assign accept      = in_valid_i && !in_stall_o;
  assign push        = accept && keep;
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (bstat_i.pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      if (push && !bstat_i.pop) count_q <= count_q + QCNT_W'(1);
      else if (!push && bstat_i.pop) count_q <= count_q - QCNT_W'(1);
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) queue_q[wr_ptr_q] <= new_cmd;
  end

endmodule

/* hdl/rarst_back.sv */
`timescale 1ns / 1ps

module rarst_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  rarst_pkg::rarst_cmd_t      cmd_i,
  output rarst_pkg::rarst_bstat_t    bstat_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [63:0]         range_sum_o
);
  import rarst_pkg::*;

  typedef enum logic [17:0] {
    S_CLEAR = 18'h00001,
    S_IDLE  = 18'h00002,
    S_PRD   = 18'h00004,
    S_PGN   = 18'h00008,
    S_PGA   = 18'h00010,
    S_PGB   = 18'h00020,
    S_PWN   = 18'h00040,
    S_LEAF  = 18'h00080,
    S_URA   = 18'h00100,
    S_URB   = 18'h00200,
    S_URN   = 18'h00400,
    S_UWN   = 18'h00800,
    S_LCHK  = 18'h01000,
    S_LLO   = 18'h02000,
    S_LLOD  = 18'h04000,
    S_LHI   = 18'h08000,
    S_LHID  = 18'h10000,
    S_OUT   = 18'h20000
  } state_e;

  state_e              state_q, state_d;
  rarst_cmd_t          cmd_q, cmd_d;
  logic                second_q, second_d;
  logic [LVL_W-1:0]    lvl_q, lvl_d;
  logic [NODE_W-1:0]   lo_q, lo_d, hi_q, hi_d;
  logic [SUM_W-1:0]    acc_q, acc_d;
  logic [SUM_W-1:0]    tag_q, tag_d;
  logic [NODE_W-1:0]   clr_q, clr_d;
  logic                out_valid_q;
  logic [SUM_W-1:0]    out_sum_q;
  logic                out_load;
  logic                push_next;

  // node memories
  logic [SUM_W-1:0]    sum_mem [NODE_COUNT];
  logic [SUM_W-1:0]    tag_mem [NODE_COUNT];
  logic [SUM_W-1:0]    sum_rd_q, tag_rd_q;
  logic                rd_en, sum_we, tag_we;
  logic [NODE_W-1:0]   rd_addr, wr_addr;
  logic [SUM_W-1:0]    wsum, wtag;

  // current path node and its children
  logic [NODE_W-1:0]   cur_b, node, child_a, child_b;
  logic [LVL_W-1:0]    push_sh;

  assign cur_b   = second_q ? cmd_q.hi : cmd_q.lo;
  assign node    = cur_b >> lvl_q;
  assign child_a = {node[NODE_W-2:0], 1'b0};
  assign child_b = {node[NODE_W-2:0], 1'b1};
  assign push_sh = lvl_q - LVL_W'(1);

  assign bstat_o.pop      = (state_q == S_IDLE) && cmd_valid_i;
  assign bstat_o.clearing = (state_q == S_CLEAR);

  // sequencer
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    second_d  = second_q;
    lvl_d     = lvl_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    acc_d     = acc_q;
    tag_d     = tag_q;
    clr_d     = clr_q;
    rd_en     = 1'b0;
    rd_addr   = node;
    sum_we    = 1'b0;
    tag_we    = 1'b0;
    wr_addr   = node;
    wsum      = '0;
    wtag      = '0;
    out_load  = 1'b0;
    push_next = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        sum_we  = 1'b1;
        tag_we  = 1'b1;
        wr_addr = clr_q;
        clr_d   = clr_q + NODE_W'(1);
        if (clr_q == NODE_W'(NODE_COUNT - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d    = cmd_i;
          second_d = 1'b0;
          lvl_d    = LVL_W'(LEVELS - 1);
          acc_d    = '0;
          state_d  = (cmd_i.kind == CMD_ZERO) ? S_OUT : S_PRD;
        end
      end
      // push down along a path
      S_PRD: begin
        rd_en   = 1'b1;
        rd_addr = node;
        state_d = S_PGN;
      end
      S_PGN: begin
        tag_d = tag_rd_q;
        if (tag_rd_q == '0) begin
          push_next = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = child_a;
          state_d = S_PGA;
        end
      end
      S_PGA: begin
        sum_we  = 1'b1;
        tag_we  = 1'b1;
        wr_addr = child_a;
        wsum    = sum_rd_q + (tag_q << push_sh);
        wtag    = tag_rd_q + tag_q;
        rd_en   = 1'b1;
        rd_addr = child_b;
        state_d = S_PGB;
      end
      S_PGB: begin
        sum_we  = 1'b1;
        tag_we  = 1'b1;
        wr_addr = child_b;
        wsum    = sum_rd_q + (tag_q << push_sh);
        wtag    = tag_rd_q + tag_q;
        state_d = S_PWN;
      end
      S_PWN: begin
        tag_we    = 1'b1;
        wr_addr   = node;
        wtag      = '0;
        push_next = 1'b1;
      end
      S_LEAF: begin
        sum_we   = 1'b1;
        wr_addr  = cmd_q.lo;
        wsum     = cmd_q.value;
        second_d = 1'b0;
        lvl_d    = LVL_W'(1);
        state_d  = S_URA;
      end
      // pull up along a path
      S_URA: begin
        rd_en   = 1'b1;
        rd_addr = child_a;
        state_d = S_URB;
      end
      S_URB: begin
        acc_d   = sum_rd_q;
        rd_en   = 1'b1;
        rd_addr = child_b;
        state_d = S_URN;
      end
      S_URN: begin
        acc_d   = acc_q + sum_rd_q;
        rd_en   = 1'b1;
        rd_addr = node;
        state_d = S_UWN;
      end
      S_UWN: begin
        sum_we  = 1'b1;
        wr_addr = node;
        wsum    = acc_q + (tag_rd_q << lvl_q);
        if (lvl_q == LVL_W'(LEVELS - 1)) begin
          if ((cmd_q.kind == CMD_ADD) && !second_q) begin
            second_d = 1'b1;
            lvl_d    = LVL_W'(1);
            state_d  = S_URA;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          lvl_d   = lvl_q + LVL_W'(1);
          state_d = S_URA;
        end
      end
      // walk both boundaries upward
      S_LCHK: begin
        if ((lo_q ^ hi_q) == NODE_W'(1)) begin
          if (cmd_q.kind == CMD_ADD) begin
            second_d = 1'b0;
            lvl_d    = LVL_W'(1);
            state_d  = S_URA;
          end else begin
            state_d = S_OUT;
          end
        end else begin
          state_d = S_LLO;
        end
      end
      S_LLO: begin
        if (!lo_q[0]) begin
          rd_en   = 1'b1;
          rd_addr = lo_q ^ NODE_W'(1);
          state_d = S_LLOD;
        end else begin
          state_d = S_LHI;
        end
      end
      S_LLOD: begin
        if (cmd_q.kind == CMD_ADD) begin
          sum_we  = 1'b1;
          tag_we  = 1'b1;
          wr_addr = lo_q ^ NODE_W'(1);
          wsum    = sum_rd_q + (cmd_q.value << lvl_q);
          wtag    = tag_rd_q + cmd_q.value;
        end else begin
          acc_d = acc_q + sum_rd_q;
        end
        state_d = S_LHI;
      end
      S_LHI: begin
        if (hi_q[0]) begin
          rd_en   = 1'b1;
          rd_addr = hi_q ^ NODE_W'(1);
          state_d = S_LHID;
        end else begin
          lo_d    = lo_q >> 1;
          hi_d    = hi_q >> 1;
          lvl_d   = lvl_q + LVL_W'(1);
          state_d = S_LCHK;
        end
      end
      S_LHID: begin
        if (cmd_q.kind == CMD_ADD) begin
          sum_we  = 1'b1;
          tag_we  = 1'b1;
          wr_addr = hi_q ^ NODE_W'(1);
          wsum    = sum_rd_q + (cmd_q.value << lvl_q);
          wtag    = tag_rd_q + cmd_q.value;
        end else begin
          acc_d = acc_q + sum_rd_q;
        end
        lo_d    = lo_q >> 1;
        hi_d    = hi_q >> 1;
        lvl_d   = lvl_q + LVL_W'(1);
        state_d = S_LCHK;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // next push level, next path or next phase
    if (push_next) begin
      if (lvl_q == LVL_W'(1)) begin
        if (cmd_q.kind == CMD_WRITE) begin
          state_d = S_LEAF;
        end else if (!second_q) begin
          second_d = 1'b1;
          lvl_d    = LVL_W'(LEVELS - 1);
          state_d  = S_PRD;
        end else begin
          lo_d    = cmd_q.lo;
          hi_d    = cmd_q.hi;
          lvl_d   = '0;
          acc_d   = '0;
          state_d = S_LCHK;
        end
      end else begin
        lvl_d   = lvl_q - LVL_W'(1);
        state_d = S_PRD;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      second_q    <= 1'b0;
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      second_q <= second_d;
      lvl_q    <= lvl_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    acc_q <= acc_d;
    tag_q <= tag_d;
    if (out_load) out_sum_q <= acc_q;
  end

  // node memory ports
  always_ff @(posedge clk_i) begin
    if (sum_we) sum_mem[wr_addr] <= wsum;
    if (tag_we) tag_mem[wr_addr] <= wtag;
    if (rd_en) begin
      sum_rd_q <= sum_mem[rd_addr];
      tag_rd_q <= tag_mem[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign range_sum_o = out_sum_q;

  // no command taken while the memories are swept
  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !bstat_o.pop)
    else $error("command popped during clearing pass");

  // pull-up writes only inner nodes
  a_pull_inner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UWN) |-> !wr_addr[NODE_W-1])
    else $error("pull-up wrote a leaf");

  // left boundary node stays below the right one during the walk
  a_walk_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LCHK) |-> (lo_q < hi_q))
    else $error("boundary nodes crossed");

  // a result is loaded only into a free or draining output register
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result overwrote a pending result");

endmodule

/* hdl/range_add_range_sum_tree.sv */
`timescale 1ns / 1ps

// Lazy segment tree over 1024 positions with point write, range add and range
// sum. After reset the block sweeps both node memories to zero, one node per
// cycle over all 2048 nodes, while in_stall_o is high. Requests are classified
// and queued two deep; a query on a bad range answers 0 without a tree walk,
// a bad range add or operation 3 is dropped. The back end owns one read and
// one write port on the node memories, so each operation works node by node:
// push-down reads each path node and, if tagged, passes the tag to both
// children; pull-up rewrites each node from its children; the boundary walk
// sums or updates sibling nodes. Results wait in an output register.
module range_add_range_sum_tree (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          operation_i,
  input  logic [9:0]          left_index_i,
  input  logic [9:0]          right_index_i,
  input  logic signed [31:0]  value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [63:0]  range_sum_o
);
  import rarst_pkg::*;

  rarst_cmd_t    cmd;
  logic          cmd_valid;
  rarst_bstat_t  bstat;

  // request front end and queue
  rarst_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .left_index_i  (left_index_i),
    .right_index_i (right_index_i),
    .value_i       (value_i),
    .bstat_i       (bstat),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd)
  );

  // tree sequencer and node memories
  rarst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .bstat_o     (bstat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .range_sum_o (range_sum_o)
  );

endmodule
